FILE: sv/ctab_pkg.sv
// Shared types, constants and the control store for the channel table allocator.
// Holds the microcode word format, the step program and the command dispatch map.
// No dependencies.
package ctab_pkg;

  localparam int ENTRY_COUNT = 8;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int ID_W        = 32;
  localparam int TIME_W      = 32;
  localparam int TMO_W       = 20;
  localparam int CMD_W       = 3;
  localparam int EIDX_W      = 6;
  localparam int OIDX_W      = 6;

  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(3000);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 3'd0,
    CMD_LOOKUP    = 3'd1,
    CMD_ALLOCATE  = 3'd2,
    CMD_EXPIRE    = 3'd3,
    CMD_SWEEP     = 3'd4,
    CMD_SET_STATE = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_AVAILABLE = 2'd0,
    ST_WAIT_INIT = 2'd1,
    ST_WAIT_CONT = 2'd2,
    ST_TIMED_OUT = 2'd3
  } ent_state_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_NO_FREE   = 2'd2
  } status_t;

  // Datapath action of one microcode step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_TICK,
    ACT_LOOKUP,
    ACT_PICK_ID,
    ACT_CLAIM,
    ACT_SWEEP,
    ACT_EXPIRE,
    ACT_LOAD_PTR,
    ACT_SET_STATE
  } act_t;

  // What a hit at the current entry does to the sequence
  typedef enum logic [1:0] {
    HIT_NONE,
    HIT_DONE,
    HIT_RESTART
  } hit_mode_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_CLR,
    PTR_LOAD
  } ptr_op_t;

  // Step addresses of the control store
  typedef enum logic [3:0] {
    U_TICK,
    U_LOOKUP,
    U_PICK,
    U_CLAIM_FIRST,
    U_SWEEP_ALLOC,
    U_CLAIM_AGAIN,
    U_EXPIRE,
    U_SWEEP,
    U_LOAD_PTR,
    U_SET_STATE,
    U_NOP
  } upc_t;

  typedef struct packed {
    act_t      act;
    logic      scan;        // walk the entries, one per cycle unless the output stalls
    hit_mode_t hit_mode;
    logic      end_done;    // finish the command when the step ends
    status_t   miss_status; // status when a hit-terminated scan finishes the command without hit
    upc_t      next_upc;
  } uword_t;

  typedef struct packed {
    act_t    act;
    logic    go;
    ptr_op_t ptr_op;
    logic    set_miss;
    status_t miss_status;
  } dp_ctl_t;

  typedef struct packed {
    logic hit;
    logic last;
  } dp_flags_t;

  typedef struct packed {
    status_t           status;
    logic [OIDX_W-1:0] index;
    logic [ID_W-1:0]   id;
  } result_t;

  // Control store: one word per step
  function automatic uword_t ucode_word(input upc_t a);
    uword_t w;
    w = '{act: ACT_NONE, scan: 1'b0, hit_mode: HIT_NONE, end_done: 1'b1,
          miss_status: STAT_OK, next_upc: U_NOP};
    unique case (a)
      U_TICK:        w.act = ACT_TICK;
      U_LOOKUP:      w = '{ACT_LOOKUP, 1'b1, HIT_DONE, 1'b1, STAT_NOT_FOUND, U_NOP};
      U_PICK:        w = '{ACT_PICK_ID, 1'b1, HIT_RESTART, 1'b0, STAT_OK, U_CLAIM_FIRST};
      U_CLAIM_FIRST: w = '{ACT_CLAIM, 1'b1, HIT_DONE, 1'b0, STAT_NO_FREE, U_SWEEP_ALLOC};
      U_SWEEP_ALLOC: w = '{ACT_SWEEP, 1'b1, HIT_NONE, 1'b0, STAT_OK, U_CLAIM_AGAIN};
      U_CLAIM_AGAIN: w = '{ACT_CLAIM, 1'b1, HIT_DONE, 1'b1, STAT_NO_FREE, U_NOP};
      U_EXPIRE:      w = '{ACT_EXPIRE, 1'b1, HIT_NONE, 1'b1, STAT_OK, U_NOP};
      U_SWEEP:       w = '{ACT_SWEEP, 1'b1, HIT_NONE, 1'b1, STAT_OK, U_NOP};
      U_LOAD_PTR:    w = '{ACT_LOAD_PTR, 1'b0, HIT_DONE, 1'b0, STAT_OK, U_SET_STATE};
      U_SET_STATE:   w.act = ACT_SET_STATE;
      U_NOP:         w.act = ACT_NONE;
      default:       w.act = ACT_NONE;
    endcase
    return w;
  endfunction

  // Dispatch map: first step of each command
  function automatic upc_t dispatch(input logic [CMD_W-1:0] cmd, input logic id_zero);
    upc_t a;
    unique case (cmd)
      CMD_TICK:      a = U_TICK;
      CMD_LOOKUP:    a = U_LOOKUP;
      CMD_ALLOCATE:  a = id_zero ? U_PICK : U_CLAIM_FIRST;
      CMD_EXPIRE:    a = U_EXPIRE;
      CMD_SWEEP:     a = U_SWEEP;
      CMD_SET_STATE: a = U_LOAD_PTR;
      default:       a = U_NOP;
    endcase
    return a;
  endfunction

endpackage

FILE: sv/ctab_datapath.sv
// Channel table datapath: entry table, tick counter, timeout register,
// candidate id, entry pointer and result register. Uses ctab_pkg.
module ctab_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_take,
  input  logic [31:0]           in_chan_id,
  input  logic [5:0]            in_entry_index,
  input  logic [1:0]            in_new_state,
  input  logic                  cfg_we,
  input  logic [19:0]           cfg_data,
  input  ctab_pkg::dp_ctl_t     ctl,
  output ctab_pkg::dp_flags_t   flags,
  output ctab_pkg::result_t     res_nxt
);
  import ctab_pkg::*;

  logic [TIME_W-1:0] tick_r;
  logic [TMO_W-1:0]  timeout_r;
  logic [ID_W-1:0]   cand_r;
  logic [EIDX_W-1:0] eidx_r;
  ent_state_t        nst_r;
  logic [IDX_W-1:0]  ptr_r;
  result_t           res_r;

  logic [ID_W-1:0]   ids_r    [ENTRY_COUNT];
  ent_state_t        states_r [ENTRY_COUNT];
  logic [TIME_W-1:0] times_r  [ENTRY_COUNT];

  logic [ID_W-1:0]   cur_id;
  ent_state_t        cur_st;
  logic [TIME_W-1:0] age;
  logic              cur_busy;
  logic              aged;
  logic              hit;

  // Read the entry under the pointer
  always_comb begin
    cur_id   = ids_r[ptr_r];
    cur_st   = states_r[ptr_r];
    age      = tick_r - times_r[ptr_r];
    cur_busy = (cur_st != ST_AVAILABLE);
    aged     = (age > TIME_W'(timeout_r));
  end

  // Per-action hit test; a candidate of zero counts as a clash so the
  // id search starts at one
  always_comb begin
    unique case (ctl.act)
      ACT_LOOKUP:   hit = (cur_id == cand_r);
      ACT_PICK_ID:  hit = (cand_r == '0) || (cur_busy && (cur_id == cand_r));
      ACT_CLAIM:    hit = !cur_busy;
      ACT_LOAD_PTR: hit = ({1'b0, eidx_r} >= (EIDX_W + 1)'(ENTRY_COUNT));
      default:      hit = 1'b0;
    endcase
    flags.hit  = hit;
    flags.last = (ptr_r == IDX_W'(ENTRY_COUNT - 1));
  end

  // Result update for this step
  always_comb begin
    res_nxt = res_r;
    if (ctl.go) begin
      unique case (ctl.act)
        ACT_LOOKUP, ACT_CLAIM: begin
          if (hit) begin
            res_nxt.status = STAT_OK;
            res_nxt.index  = OIDX_W'(ptr_r);
            res_nxt.id     = cand_r;
          end
        end
        ACT_LOAD_PTR: begin
          if (hit) res_nxt.status = STAT_NOT_FOUND;
        end
        ACT_SET_STATE: begin
          res_nxt.index = OIDX_W'(ptr_r);
          res_nxt.id    = cur_id;
        end
        default: ;
      endcase
      if (ctl.set_miss) res_nxt.status = ctl.miss_status;
    end
  end

  // Table, counters and request registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      timeout_r <= TMO_RESET;
      ptr_r     <= '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        ids_r[i]    <= '0;
        states_r[i] <= ST_AVAILABLE;
        times_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) timeout_r <= cfg_data;
      if (in_take) begin
        cand_r <= in_chan_id;
        eidx_r <= in_entry_index;
        nst_r  <= ent_state_t'(in_new_state);
        ptr_r  <= '0;
        res_r  <= '{status: STAT_OK, index: '0, id: '0};
      end else if (ctl.go) begin
        res_r <= res_nxt;
        unique case (ctl.ptr_op)
          PTR_INC:  ptr_r <= ptr_r + 1'b1;
          PTR_CLR:  ptr_r <= '0;
          PTR_LOAD: ptr_r <= eidx_r[IDX_W-1:0];
          default:  ;
        endcase
        unique case (ctl.act)
          ACT_TICK: tick_r <= tick_r + 1'b1;
          ACT_LOOKUP: begin
            if (hit) times_r[ptr_r] <= tick_r;
          end
          ACT_PICK_ID: begin
            if (hit) cand_r <= cand_r + 1'b1;
          end
          ACT_CLAIM: begin
            if (hit) begin
              ids_r[ptr_r]    <= cand_r;
              states_r[ptr_r] <= ST_WAIT_INIT;
              times_r[ptr_r]  <= tick_r;
            end
          end
          ACT_SWEEP: begin
            if (cur_busy && aged) states_r[ptr_r] <= ST_AVAILABLE;
          end
          ACT_EXPIRE: begin
            if (cur_st == ST_WAIT_CONT) states_r[ptr_r] <= ST_TIMED_OUT;
          end
          ACT_SET_STATE: states_r[ptr_r] <= nst_r;
          default: ;
        endcase
      end
    end
  end

  // A claimed entry never gets id zero
  a_claim_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.go && (ctl.act == ACT_CLAIM) && hit) |=> (res_r.id != '0))
    else $error("claimed entry with id zero");

endmodule

FILE: sv/ctab_sequencer.sv
// Microcode sequencer: step counter, control store lookup and
// hit/end driven branching. Uses ctab_pkg.
module ctab_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  logic [2:0]           in_command,
  input  logic                 in_id_zero,
  input  logic                 out_block,
  input  ctab_pkg::dp_flags_t  flags,
  output ctab_pkg::dp_ctl_t    ctl,
  output logic                 busy,
  output logic                 finish
);
  import ctab_pkg::*;

  upc_t   upc_r, upc_nxt;
  logic   busy_r, busy_nxt;
  uword_t word;
  logic   go;
  logic   step_end;

  assign word = ucode_word(upc_r);
  assign go   = busy_r && !out_block;
  assign busy = busy_r;

  // Branch on the datapath flags
  always_comb begin
    upc_nxt         = upc_r;
    busy_nxt        = busy_r;
    finish          = 1'b0;
    step_end        = !word.scan || flags.last;
    ctl.act         = word.act;
    ctl.go          = go;
    ctl.ptr_op      = PTR_HOLD;
    ctl.set_miss    = 1'b0;
    ctl.miss_status = word.miss_status;
    if (in_take) begin
      upc_nxt  = dispatch(in_command, in_id_zero);
      busy_nxt = 1'b1;
    end else if (go) begin
      priority if ((word.hit_mode == HIT_RESTART) && flags.hit) begin
        ctl.ptr_op = PTR_CLR;
      end else if ((word.hit_mode == HIT_DONE) && flags.hit) begin
        finish = 1'b1;
      end else if (step_end) begin
        if (word.end_done) begin
          finish       = 1'b1;
          ctl.set_miss = (word.hit_mode == HIT_DONE);
        end else begin
          upc_nxt    = word.next_upc;
          ctl.ptr_op = (word.act == ACT_LOAD_PTR) ? PTR_LOAD : PTR_CLR;
        end
      end else begin
        ctl.ptr_op = PTR_INC;
      end
      if (finish) busy_nxt = 1'b0;
    end
  end

  // Hold step counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= U_NOP;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> !busy_r)
    else $error("command taken while sequencer busy");

  a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> !busy_r)
    else $error("sequencer still busy after finish");

endmodule

FILE: sv/channel_table_allocator.sv
// Lookup, expire and sweep scan the entry table; allocate scans it too and, for a zero id,
// first searches for a new id, one entry per cycle while the output register is not stalled.
// Throughput: one command at a time; the next transfer is taken once the result is in the
// output register. Reset clears the table to available, tick count and ids to zero and the
// timeout to 3000 ticks; no clearing pass is needed.
module channel_table_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_chan_id,
  input  logic [5:0]  in_entry_index,
  input  logic [1:0]  in_new_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_index,
  output logic [31:0] out_id_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);
  import ctab_pkg::*;

  logic      in_take;
  logic      busy;
  logic      finish;
  logic      out_block;
  dp_ctl_t   ctl;
  dp_flags_t flags;
  result_t   res_nxt;
  logic      out_valid_r;
  result_t   out_r;

  assign in_stall  = busy;
  assign in_take   = in_valid && !busy;
  assign cfg_ready = !busy;
  assign out_block = out_valid_r && out_stall;

  ctab_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_command (in_command),
    .in_id_zero (in_chan_id == '0),
    .out_block  (out_block),
    .flags      (flags),
    .ctl        (ctl),
    .busy       (busy),
    .finish     (finish)
  );

  ctab_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_take        (in_take),
    .in_chan_id     (in_chan_id),
    .in_entry_index (in_entry_index),
    .in_new_state   (in_new_state),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .ctl            (ctl),
    .flags          (flags),
    .res_nxt        (res_nxt)
  );

  // Output register: load on finish, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) out_r <= res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_r.status;
  assign out_index  = out_r.index;
  assign out_id_out = out_r.id;

  a_take_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("not busy after input transfer");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(finish))
    else $error("result appeared without finish");

  a_finish_fills: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("finish did not load the output register");

endmodule
